### src/sem_pkg.sv
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WCFG_W     = 11;
	localparam int HCFG_W     = 13;
	localparam int SUM_W      = 21;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
	localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic       flush;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       last_of_frame;
	} pixel_out_t;

	typedef logic [8:0][7:0] tap_vec_t;

endpackage

### src/sem_lane.sv
module sem_lane import sem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  tap_vec_t   taps,
	output logic       done,
	output logic [7:0] mag
);

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_SQ   = 4'b0010,
		L_ROOT = 4'b0100,
		L_DONE = 4'b1000
	} lane_state_t;

	lane_state_t state_q;
	logic signed [10:0] gx_q, gy_q;
	logic [SUM_W-1:0] s_q;
	logic [7:0] q_q, bit_q;
	logic signed [10:0] v [9];
	logic signed [10:0] gx, gy;
	logic signed [21:0] gx2, gy2;
	logic [7:0] t;
	logic [15:0] tt;
	logic [15:0] qsq;
	logic [16:0] qq;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			v[i] = {3'b000, taps[i]};
		end
		gx = v[2] - v[0] + v[5] + v[5] - v[3] - v[3] + v[8] - v[6];
		gy = v[6] - v[0] + v[7] + v[7] - v[1] - v[1] + v[8] - v[2];
		gx2 = gx_q * gx_q;
		gy2 = gy_q * gy_q;
		t = q_q | bit_q;
		tt = t * t;
		qsq = q_q * q_q;
		qq = {1'b0, qsq} + {9'd0, q_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE: if (start) state_q <= L_SQ;
				L_SQ: state_q <= L_ROOT;
				L_ROOT: if (bit_q[0]) state_q <= L_DONE;
				L_DONE: state_q <= L_IDLE;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			gx_q <= gx;
			gy_q <= gy;
		end
		if (state_q == L_SQ) begin
			s_q   <= SUM_W'(gx2) + SUM_W'(gy2);
			q_q   <= 8'd0;
			bit_q <= 8'h80;
		end
		if (state_q == L_ROOT) begin
			if ({5'd0, tt} <= s_q) q_q <= t;
			bit_q <= bit_q >> 1;
		end
	end

	assign done = (state_q == L_DONE);
	assign mag  = (s_q > SUM_W'(65280)) ? 8'd255 :
		(s_q > {4'd0, qq}) ? q_q + 8'd1 : q_q;

endmodule

### src/sobel_edge_magnitude_rgb.sv
// Streaming 3x3 Sobel gradient magnitude on RGB pixels.
// Pixels enter in raster order on in_valid/in_ready with payload in_data.
// The frame size is set through cfg_valid/cfg_ready, cfg_index and cfg_data:
// index 0 is the frame width (1 to 1024), index 1 the frame height (1 to 4096).
// Write them only while the block is idle; cfg_ready is always high.
// The result for pixel n leaves on out_data with the item n+W+1, W being the
// width, so after each frame the host sends W+1 items with flush set.
// One item is handled at a time. An item with a result passes the read, start,
// calculation and output states, waiting in calculation for the eight-step square
// root in the three channel lanes; one without a result goes idle after start.
// Results sit in an output register; while the receiver stalls, the block
// keeps accepting items until one more result is finished, then waits until
// the register frees.
// Reset restores width 640 and height 480, clears the window and the position,
// and empties the output register. Line stores need no clearing, since entries
// never written only reach padded window taps.
module sobel_edge_magnitude_rgb import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pixel_in_t         in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pixel_out_t        out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [HCFG_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_START = 5'b00100,
		S_CALC  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [ADDR_W-1:0] col_q, c_s1;
	logic [HCFG_W-1:0] row_q, r_s1;
	logic [23:0] px_s1, top_q, mid_q;
	logic [23:0] upper_mem [MAX_WIDTH];
	logic [23:0] middle_mem [MAX_WIDTH];
	logic [8:0][23:0] win_q;
	logic [8:0] pad_q;
	logic valid_q, last_q;
	logic out_valid_q;
	pixel_out_t out_q;
	logic [7:0] mag_red_q, mag_green_q, mag_blue_q;

	logic [WCFG_W-1:0] w;
	logic [HCFG_W-1:0] h, h1;
	logic accept, wrap;
	logic [ADDR_W-1:0] c;
	logic [HCFG_W-1:0] r;
	logic [WCFG_W-1:0] c_next;
	logic [WCFG_W-1:0] cc;
	logic [HCFG_W-1:0] cr;
	logic cur_valid;
	logic [8:0] pad;
	tap_vec_t taps [3];
	logic [2:0] lane_done;
	logic [7:0] lane_mag [3];
	logic load_out;

	always_comb begin
		w = (width_q == '0) ? WCFG_W'(1) :
			(width_q > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : width_q;
		h = (height_q == '0) ? HCFG_W'(1) :
			(height_q > HCFG_W'(MAX_HEIGHT)) ? HCFG_W'(MAX_HEIGHT) : height_q;
		h1 = h + HCFG_W'(1);
		accept = in_valid && in_ready;
		wrap = ({1'b0, col_q} >= w) || (row_q > h1) || (row_q == h1 && col_q != '0);
		c = wrap ? '0 : col_q;
		r = wrap ? '0 : row_q;
		c_next = {1'b0, c} + WCFG_W'(1);

		cur_valid = 1'b0;
		cc = '0;
		cr = '0;
		if (c_s1 != '0) begin
			if (r_s1 >= HCFG_W'(1) && r_s1 <= h) begin
				cur_valid = 1'b1;
				cr = r_s1 - HCFG_W'(1);
				cc = {1'b0, c_s1} - WCFG_W'(1);
			end
		end else if (r_s1 >= HCFG_W'(2)) begin
			cur_valid = 1'b1;
			cr = r_s1 - HCFG_W'(2);
			cc = w - WCFG_W'(1);
		end
		for (int i = 0; i < 9; i++) begin
			pad[i] = ((i % 3 == 0) && cc == '0) || ((i % 3 == 2) && cc + WCFG_W'(1) == w) ||
				((i / 3 == 0) && cr == '0) || ((i / 3 == 2) && cr + HCFG_W'(1) == h);
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 9; i++) begin
				taps[k][i] = pad_q[i] ? 8'd0 : win_q[i][8*k +: 8];
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
			col_q       <= '0;
			row_q       <= '0;
			win_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  width_q <= cfg_data[WCFG_W-1:0];
					REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (r == h1) begin
					col_q <= '0;
					row_q <= '0;
				end else if (c_next >= w) begin
					col_q <= '0;
					row_q <= r + HCFG_W'(1);
				end else begin
					col_q <= c_next[ADDR_W-1:0];
					row_q <= r;
				end
			end
			if (state_q == S_READ) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i*3]   <= win_q[i*3+1];
					win_q[i*3+1] <= win_q[i*3+2];
				end
				win_q[2] <= top_q;
				win_q[5] <= mid_q;
				win_q[8] <= px_s1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (accept) state_q <= S_READ;
				S_READ:  state_q <= S_START;
				S_START: state_q <= valid_q ? S_CALC : S_IDLE;
				S_CALC:  if (lane_done[0]) state_q <= S_OUT;
				S_OUT:   if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1  <= c;
			r_s1  <= r;
			px_s1 <= in_data.flush ? 24'd0 :
				{in_data.in_blue, in_data.in_green, in_data.in_red};
			top_q <= upper_mem[c];
			mid_q <= middle_mem[c];
		end
		if (state_q == S_READ) begin
			upper_mem[c_s1]  <= mid_q;
			middle_mem[c_s1] <= px_s1;
			pad_q   <= pad;
			valid_q <= cur_valid;
			last_q  <= (cr + HCFG_W'(1) == h) && (cc + WCFG_W'(1) == w);
		end
		if (state_q == S_CALC && lane_done[0]) begin
			mag_red_q   <= lane_mag[0];
			mag_green_q <= lane_mag[1];
			mag_blue_q  <= lane_mag[2];
		end
		if (load_out) begin
			out_q.out_red       <= mag_red_q;
			out_q.out_green     <= mag_green_q;
			out_q.out_blue      <= mag_blue_q;
			out_q.last_of_frame <= last_q;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		sem_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == S_START && valid_q),
			.taps   (taps[k]),
			.done   (lane_done[k]),
			.mag    (lane_mag[k])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
		else $error("channel lanes out of step");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> state_q == S_CALC)
		else $error("lane finished outside the calculation state");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

### verif/sobel_edge_magnitude_rgb_tb.sv
module sobel_edge_magnitude_rgb_tb import sem_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic       is_cfg;
		logic [0:0] idx;
		logic [HCFG_W-1:0] data;
		pixel_in_t  px;
		logic       fixed;
		pixel_out_t res;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	pixel_in_t in_data;
	pixel_out_t out_data;
	logic [0:0] cfg_index;
	logic [HCFG_W-1:0] cfg_data;

	sobel_edge_magnitude_rgb DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [WCFG_W-1:0] width_reg;
	logic [HCFG_W-1:0] height_reg;
	logic [23:0] upper_line [MAX_WIDTH];
	logic [23:0] middle_line [MAX_WIDTH];
	logic [23:0] win [9];
	int unsigned col_pos, row_pos;

	pixel_out_t magnitudes_due[$];
	int errors;
	int mismatches;
	int cycles;
	bit quiet;
	bit hold_req;
	int hold_left;
	int items_sent;

	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] gradient_mag(int gx, int gy);
		int unsigned s, q, t;
		s = gx * gx + gy * gy;
		q = 0;
		for (int b = 11; b >= 0; b--) begin
			t = q | (1 << b);
			if (t * t <= s)
				q = t;
		end
		if (s > q * q + q)
			q++;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	task automatic apply_setting(logic [0:0] idx, logic [HCFG_W-1:0] data);
		if (idx == REG_FRAME_WIDTH)
			width_reg = data[WCFG_W-1:0];
		else
			height_reg = data;
	endtask

	task automatic advance_window(pixel_in_t p, output bit has, output pixel_out_t o);
		int unsigned w, h, c, r, cr, cc;
		logic [23:0] px, top, mid;
		int v [9];
		int gx, gy;
		bit pad;
		w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg < 1) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		has = 1'b0;
		o = '0;
		cr = 0;
		cc = 0;
		if (col_pos >= w || row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		px = p.flush ? 24'd0 : {p.in_blue, p.in_green, p.in_red};
		top = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = px;
		for (int i = 0; i < 3; i++) begin
			win[i*3] = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		if (c >= 1) begin
			if (r >= 1 && r <= h) begin
				has = 1'b1;
				cr = r - 1;
				cc = c - 1;
			end
		end else if (r >= 2) begin
			has = 1'b1;
			cr = r - 2;
			cc = w - 1;
		end
		if (r == h + 1) begin
			col_pos = 0;
			row_pos = 0;
		end else begin
			col_pos = c + 1;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
			end
		end
		if (has) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 9; i++) begin
					pad = (i % 3 == 0 && cc == 0) || (i % 3 == 2 && cc + 1 == w) ||
						(i / 3 == 0 && cr == 0) || (i / 3 == 2 && cr + 1 == h);
					v[i] = pad ? 0 : int'(win[i][8*ch +: 8]);
				end
				gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
				gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
				case (ch)
					0: o.out_red = gradient_mag(gx, gy);
					1: o.out_green = gradient_mag(gx, gy);
					default: o.out_blue = gradient_mag(gx, gy);
				endcase
			end
			o.last_of_frame = (cr + 1 == h && cc + 1 == w);
		end
	endtask

	task automatic pause_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pixel(pixel_in_t p, bit fixed = 1'b0, pixel_out_t res = '0);
		bit has;
		pixel_out_t o;
		if (!quiet && $urandom_range(99) < 6)
			pause_input($urandom_range(1, 4));
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		advance_window(p, has, o);
		if (fixed)
			magnitudes_due.push_back(res);
		else if (has)
			magnitudes_due.push_back(o);
		items_sent++;
		if (items_sent == 300)
			hold_req = 1'b1;
	endtask

	task automatic write_setting(logic [0:0] idx, logic [HCFG_W-1:0] data);
		in_valid <= 1'b0;
		while (magnitudes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
		cfg_valid <= 1'b0;
	endtask

	function automatic pixel_in_t random_pixel(bit flush);
		pixel_in_t p;
		p.in_red = $urandom;
		p.in_green = $urandom;
		p.in_blue = $urandom;
		p.flush = flush;
		return p;
	endfunction

	task automatic send_frame(int w, int h, bit broken);
		int n;
		write_setting(REG_FRAME_WIDTH, w);
		write_setting(REG_FRAME_HEIGHT, h);
		n = broken ? $urandom_range(1, w * h) : w * h;
		for (int i = 0; i < n; i++)
			send_pixel(random_pixel($urandom_range(19) == 0));
		if (!broken)
			for (int i = 0; i <= w; i++)
				send_pixel(random_pixel($urandom_range(3) != 0));
	endtask

	step_row_t directed [] = '{
		'{1'b1, REG_FRAME_WIDTH, 13'd0, '0, 1'b0, '0},
		'{1'b1, REG_FRAME_HEIGHT, 13'd0, '0, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hAA, 8'h55, 8'hAA, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
		'{1'b1, REG_FRAME_WIDTH, 13'd3, '0, 1'b0, '0},
		'{1'b1, REG_FRAME_HEIGHT, 13'd2, '0, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{1'b1, REG_FRAME_WIDTH, 13'd2047, '0, 1'b0, '0},
		'{1'b1, REG_FRAME_HEIGHT, 13'd8191, '0, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h01, 8'h80, 8'hFE, 1'b0}, 1'b0, '0},
		'{1'b0, 1'b0, 13'd0, '{8'h7F, 8'h01, 8'h80, 1'b0}, 1'b0, '0}
	};

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_req <= 1'b0;
			hold_left <= 400;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (magnitudes_due.size() == 0) begin
				errors++;
				$display("Unexpected result %h at %0t", out_data, $realtime);
			end else begin
				if (out_data !== magnitudes_due[0]) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected %h, got %h",
							$realtime, magnitudes_due[0], out_data);
				end
				void'(magnitudes_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		mismatches = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		items_sent = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		col_pos = 0;
		row_pos = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_setting(directed[i].idx, directed[i].data);
			else
				send_pixel(directed[i].px, directed[i].fixed, directed[i].res);
		end

		while (items_sent < 650) begin
			quiet = (items_sent > 400 && items_sent < 520);
			if ($urandom_range(7) == 0)
				send_frame($urandom_range(1, 40), $urandom_range(1, 6), $urandom_range(9) == 0);
			else
				send_frame($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(9) == 0);
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (magnitudes_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
